// ===== rtl/core/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types, register codes and constants of the feedback delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

   localparam int MAX_DELAY_DEF = 65536;
   localparam int CHANNELS_DEF  = 2;
   localparam int MAX_BLOCK_DEF = 4096;

   localparam int SAMPLE_W   = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY_LENGTH  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEEDBACK_GAIN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WET_MIX       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_BEGIN    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_STEP     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLOCK_LENGTH  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 3'd6;

   localparam logic [16:0] DELAY_LENGTH_RST  = 17'd48000;
   localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd16384;
   localparam logic [15:0] WET_MIX_RST       = 16'd16384;
   localparam logic [23:0] GAIN_BEGIN_RST    = 24'd4194304;
   localparam logic [24:0] GAIN_STEP_RST     = 25'd0;
   localparam logic [12:0] BLOCK_LENGTH_RST  = 13'd512;
   localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd2;

   localparam logic [15:0] UNITY_Q15 = 16'd32768;
   localparam int GAIN_FRAC = 22;
   localparam int MIX_FRAC  = 15;
   localparam int WET_W     = 26;
   localparam int MUL_A_W   = 27;
   localparam int MUL_B_W   = 25;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SAT_IN_W  = 40;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       channel;
   } fdl_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       channel_out;
   } fdl_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fdl_rem_status_type;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 40'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -40'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/fdl_remainder.sv =====
// ----------------------------------------------------------------------------
// fdl_remainder
// Restoring remainder unit: one dividend bit per cycle, used to fold a ring
// position back into a shortened ring.
// ----------------------------------------------------------------------------
module fdl_remainder #(
   parameter  int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF,
   localparam int PW        = $clog2(MAX_DELAY),
   localparam int LW        = $clog2(MAX_DELAY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [PW-1:0]                dividend,
   input  logic [LW-1:0]                divisor,
   output logic [PW-1:0]                remainder,
   output fdl_pkg::fdl_rem_status_type  status
);

   localparam int CNW = $clog2(PW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW:0]   trial;
   logic [LW:0]   diff;

   assign trial = {rem_ff, quo_ff[PW-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(PW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         rem_in = (trial >= {1'b0, divisor}) ? diff[LW-1:0] : trial[LW-1:0];
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign remainder   = rem_ff[PW-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/feedback_delay_line.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_line
// Multichannel feedback echo with a ramped wet gain and one shared multiplier.
//
// Samples arrive on req_* as interleaved frames, channel 0 first; each
// transfer yields one result on rsp_*. The user must write registers on csr_*
// only while the block is idle; the block itself does not enforce this. The
// five products of a sample run one after another through a single 27x25
// multiplier, and the delay memory is read once and written once through its
// one port. When the ring position lies at or beyond a shortened ring, the
// remainder unit folds it back into the ring first. A channel at or beyond
// the channel count passes its sample through and touches no state.
// After reset the delay memory is cleared, one entry a cycle, through all
// CHANNELS*MAX_DELAY entries; req_ready stays low until then.
// req_ready is high only while the block is idle between samples.
// The result waits in an output register while the receiver stalls; the
// next sample is taken meanwhile and held in its last step until the
// register frees.
// ----------------------------------------------------------------------------
module feedback_delay_line #(
   parameter int MAX_DELAY = fdl_pkg::MAX_DELAY_DEF,
   parameter int CHANNELS  = fdl_pkg::CHANNELS_DEF,
   parameter int MAX_BLOCK = fdl_pkg::MAX_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fdl_pkg::fdl_req_type               req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fdl_pkg::fdl_rsp_type               rsp_payload,
   input  logic                               csr_we,
   input  logic [fdl_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [fdl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DEPTH   = CHANNELS * MAX_DELAY;
   localparam int AW      = $clog2(DEPTH);
   localparam int PW      = $clog2(MAX_DELAY);
   localparam int LW      = $clog2(MAX_DELAY + 1);
   localparam int CW      = (LW > 17) ? LW : 17;
   localparam int FW      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int BLW     = $clog2(MAX_BLOCK + 1);
   localparam int BCW     = (BLW > 13) ? BLW : 13;
   localparam int CCW     = $clog2(CHANNELS + 1);
   localparam int CCC     = (CCW > 2) ? CCW : 2;
   localparam int SW      = fdl_pkg::SAMPLE_W;
   localparam int PROD_W  = fdl_pkg::PROD_W;
   localparam int A_W     = fdl_pkg::MUL_A_W;
   localparam int B_W     = fdl_pkg::MUL_B_W;
   localparam int WET_W   = fdl_pkg::WET_W;
   localparam int GF      = fdl_pkg::GAIN_FRAC;
   localparam int MF      = fdl_pkg::MIX_FRAC;
   localparam int MQ_W    = PROD_W + 1 - MF;
   localparam int FQ_W    = PROD_W - MF;
   localparam int SAT_W   = fdl_pkg::SAT_IN_W;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_MOD   = 4'd3;
   localparam logic [3:0] S_GAIN  = 4'd4;
   localparam logic [3:0] S_SAT   = 4'd5;
   localparam logic [3:0] S_WET   = 4'd6;
   localparam logic [3:0] S_DRY   = 4'd7;
   localparam logic [3:0] S_MIX   = 4'd8;
   localparam logic [3:0] S_FB    = 4'd9;
   localparam logic [3:0] S_WB    = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   logic [3:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [FW-1:0]              frame_ff, frame_in;
   logic [16:0]                delay_length_ff, delay_length_in;
   logic [15:0]                feedback_gain_ff, feedback_gain_in;
   logic [15:0]                wet_mix_ff, wet_mix_in;
   logic [23:0]                gain_begin_ff, gain_begin_in;
   logic signed [24:0]         gain_step_ff, gain_step_in;
   logic [12:0]                block_length_ff, block_length_in;
   logic [1:0]                 channel_count_ff, channel_count_in;
   logic signed [SW-1:0]       dry_ff, dry_in;
   logic                       ch_ff, ch_in;
   logic signed [PROD_W-1:0]   p_ff, p_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic [23:0]                gain_ff, gain_in;
   logic signed [WET_W-1:0]    wet_ff, wet_in;
   logic signed [SW-1:0]       result_ff, result_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fdl_pkg::fdl_rsp_type       rsp_payload_ff, rsp_payload_in;
   logic signed [SW-1:0]       rd_ff;

   logic [SW-1:0]              mem [DEPTH];
   logic                       mem_we;
   logic                       mem_re;
   logic [AW-1:0]              mem_addr;
   logic [AW-1:0]              item_addr;
   logic [SW-1:0]              mem_wdata;

   logic [CW-1:0]              len_c;
   logic [LW-1:0]              len_eff;
   logic [BCW-1:0]             blk_c;
   logic [BLW-1:0]             blk_eff;
   logic [CCC-1:0]             cc_eff;
   logic [15:0]                mix_eff;
   logic [15:0]                fb_eff;
   logic [15:0]                dry_share;
   logic                       bypass;
   logic                       last_ch;
   logic [LW-1:0]              pos_inc;
   logic [BLW-1:0]             frame_inc;

   logic signed [A_W-1:0]      mul_a;
   logic signed [B_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]   prod;

   logic signed [PROD_W:0]     gsum;
   logic signed [PROD_W-1:0]   wet_t;
   logic signed [PROD_W:0]     mix_t;
   logic signed [MQ_W-1:0]     mixed_q;
   logic signed [PROD_W-1:0]   fb_t;
   logic signed [FQ_W-1:0]     fb_q;
   logic signed [FQ_W:0]       back_sum;
   logic signed [SW-1:0]       back_sat;

   logic                       rem_start;
   logic [PW-1:0]              rem_value;
   fdl_pkg::fdl_rem_status_type rem_status;

   fdl_remainder #(
      .MAX_DELAY (MAX_DELAY)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (pos_ff),
      .divisor   (len_eff),
      .remainder (rem_value),
      .status    (rem_status)
   );

   // effective register values
   always_comb begin
      if (delay_length_ff == '0) begin
         len_c = CW'(1);
      end else if (CW'(delay_length_ff) > CW'(MAX_DELAY)) begin
         len_c = CW'(MAX_DELAY);
      end else begin
         len_c = CW'(delay_length_ff);
      end
      if (block_length_ff == '0) begin
         blk_c = BCW'(1);
      end else if (BCW'(block_length_ff) > BCW'(MAX_BLOCK)) begin
         blk_c = BCW'(MAX_BLOCK);
      end else begin
         blk_c = BCW'(block_length_ff);
      end
      if (channel_count_ff == '0) begin
         cc_eff = CCC'(1);
      end else if (CCC'(channel_count_ff) > CCC'(CHANNELS)) begin
         cc_eff = CCC'(CHANNELS);
      end else begin
         cc_eff = CCC'(channel_count_ff);
      end
   end

   assign len_eff   = len_c[LW-1:0];
   assign blk_eff   = blk_c[BLW-1:0];
   assign mix_eff   = (wet_mix_ff > fdl_pkg::UNITY_Q15) ? fdl_pkg::UNITY_Q15 : wet_mix_ff;
   assign fb_eff    = (feedback_gain_ff > fdl_pkg::UNITY_Q15) ? fdl_pkg::UNITY_Q15
                                                              : feedback_gain_ff;
   assign dry_share = fdl_pkg::UNITY_Q15 - mix_eff;
   assign bypass    = (CCC'(ch_ff) >= cc_eff);
   assign last_ch   = (CCC'(ch_ff) == (cc_eff - CCC'(1)));
   assign pos_inc   = LW'(pos_ff) + LW'(1);
   assign frame_inc = BLW'(frame_ff) + BLW'(1);
   assign item_addr = (ch_ff ? AW'(MAX_DELAY) : AW'(0)) + AW'(pos_ff);

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         S_GAIN: begin
            mul_a = $signed({{(A_W-FW){1'b0}}, frame_ff});
            mul_b = gain_step_ff;
         end
         S_WET: begin
            mul_a = A_W'(rd_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         S_DRY: begin
            mul_a = A_W'(dry_ff);
            mul_b = $signed({{(B_W-16){1'b0}}, dry_share});
         end
         S_MIX: begin
            mul_a = A_W'(wet_ff);
            mul_b = $signed({{(B_W-16){1'b0}}, mix_eff});
         end
         S_FB: begin
            mul_a = A_W'(wet_ff);
            mul_b = $signed({{(B_W-16){1'b0}}, fb_eff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // rounding and saturation
   assign gsum     = {p_ff[PROD_W-1], p_ff} + {{(PROD_W+1-24){1'b0}}, gain_begin_ff};
   assign wet_t    = p_ff + (PROD_W'(1) <<< (GF - 1));
   assign mix_t    = {acc_ff[PROD_W-1], acc_ff} + {p_ff[PROD_W-1], p_ff}
                     + ((PROD_W+1)'(1) <<< (MF - 1));
   assign mixed_q  = mix_t[PROD_W:MF];
   assign fb_t     = p_ff + (PROD_W'(1) <<< (MF - 1));
   assign fb_q     = fb_t[PROD_W-1:MF];
   assign back_sum = (FQ_W+1)'(fb_q) + (FQ_W+1)'(dry_ff);
   assign back_sat = fdl_pkg::sat24(SAT_W'(back_sum));

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      pos_in           = pos_ff;
      frame_in         = frame_ff;
      delay_length_in  = delay_length_ff;
      feedback_gain_in = feedback_gain_ff;
      wet_mix_in       = wet_mix_ff;
      gain_begin_in    = gain_begin_ff;
      gain_step_in     = gain_step_ff;
      block_length_in  = block_length_ff;
      channel_count_in = channel_count_ff;
      dry_in           = dry_ff;
      ch_in            = ch_ff;
      p_in             = p_ff;
      acc_in           = acc_ff;
      gain_in          = gain_ff;
      wet_in           = wet_ff;
      result_in        = result_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_payload_in   = rsp_payload_ff;
      rem_start        = 1'b0;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_addr         = item_addr;
      mem_wdata        = back_sat;

      if (csr_we) begin
         case (csr_index)
            fdl_pkg::CSR_DELAY_LENGTH:  delay_length_in  = csr_wdata[16:0];
            fdl_pkg::CSR_FEEDBACK_GAIN: feedback_gain_in = csr_wdata[15:0];
            fdl_pkg::CSR_WET_MIX:       wet_mix_in       = csr_wdata[15:0];
            fdl_pkg::CSR_GAIN_BEGIN:    gain_begin_in    = csr_wdata[23:0];
            fdl_pkg::CSR_GAIN_STEP:     gain_step_in     = $signed(csr_wdata[24:0]);
            fdl_pkg::CSR_BLOCK_LENGTH:  block_length_in  = csr_wdata[12:0];
            fdl_pkg::CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[1:0];
            default: ;
         endcase
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               dry_in   = req_payload.sample_in;
               ch_in    = req_payload.channel;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (bypass) begin
               result_in = dry_ff;
               state_in  = S_DONE;
            end else begin
               if (BLW'(frame_ff) >= blk_eff) begin
                  frame_in = '0;
               end
               if (LW'(pos_ff) >= len_eff) begin
                  rem_start = 1'b1;
                  state_in  = S_MOD;
               end else begin
                  state_in = S_GAIN;
               end
            end
         end
         S_MOD: begin
            if (rem_status.done) begin
               pos_in   = rem_value;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            mem_re   = 1'b1;
            p_in     = prod;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (gsum[PROD_W]) begin
               gain_in = '0;
            end else if (|gsum[PROD_W-1:24]) begin
               gain_in = '1;
            end else begin
               gain_in = gsum[23:0];
            end
            state_in = S_WET;
         end
         S_WET: begin
            p_in     = prod;
            state_in = S_DRY;
         end
         S_DRY: begin
            wet_in   = wet_t[GF+WET_W-1:GF];
            p_in     = prod;
            state_in = S_MIX;
         end
         S_MIX: begin
            acc_in   = p_ff;
            p_in     = prod;
            state_in = S_FB;
         end
         S_FB: begin
            result_in = fdl_pkg::sat24(SAT_W'(mixed_q));
            p_in      = prod;
            state_in  = S_WB;
         end
         S_WB: begin
            mem_we = 1'b1;
            if (last_ch) begin
               pos_in   = (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];
               frame_in = (frame_inc >= blk_eff) ? '0 : frame_inc[FW-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.sample_out  = result_ff;
               rsp_payload_in.channel_out = ch_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_ff           <= '0;
         pos_ff           <= '0;
         frame_ff         <= '0;
         delay_length_ff  <= fdl_pkg::DELAY_LENGTH_RST;
         feedback_gain_ff <= fdl_pkg::FEEDBACK_GAIN_RST;
         wet_mix_ff       <= fdl_pkg::WET_MIX_RST;
         gain_begin_ff    <= fdl_pkg::GAIN_BEGIN_RST;
         gain_step_ff     <= $signed(fdl_pkg::GAIN_STEP_RST);
         block_length_ff  <= fdl_pkg::BLOCK_LENGTH_RST;
         channel_count_ff <= fdl_pkg::CHANNEL_COUNT_RST;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         pos_ff           <= pos_in;
         frame_ff         <= frame_in;
         delay_length_ff  <= delay_length_in;
         feedback_gain_ff <= feedback_gain_in;
         wet_mix_ff       <= wet_mix_in;
         gain_begin_ff    <= gain_begin_in;
         gain_step_ff     <= gain_step_in;
         block_length_ff  <= block_length_in;
         channel_count_ff <= channel_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      dry_ff         <= dry_in;
      ch_ff          <= ch_in;
      p_ff           <= p_in;
      acc_ff         <= acc_in;
      gain_ff        <= gain_in;
      wet_ff         <= wet_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= $signed(mem[mem_addr]);
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAIN) |-> ((LW'(pos_ff) < len_eff) && (BLW'(frame_ff) < blk_eff)))
      else $error("ring position or frame out of range at memory read");

   a_rem_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == S_MOD))
      else $error("remainder finished outside its wait step");

   a_wb_not_bypass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> (!bypass && $past(state_ff) == S_FB))
      else $error("write-back reached for a pass-through channel");

   a_clear_blocks_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (clr_ff == '0))
      else $error("transfer taken before the memory clear completed");

endmodule
